// ===== rtl/bte_pkg.sv =====
// Shared types and constants for the bitmap transform engine.
package bte_pkg;

  localparam int unsigned FuncW  = 4;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned DataW  = 16;
  localparam int unsigned InBits = FuncW + IdxW + DataW;
  localparam int unsigned InTdataW = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((DataW + 7) / 8) * 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE  = 4'd0,
    FUNC_READ   = 4'd1,
    FUNC_INVERT = 4'd2,
    FUNC_UP     = 4'd3,
    FUNC_DOWN   = 4'd4,
    FUNC_LEFT   = 4'd5,
    FUNC_RIGHT  = 4'd6,
    FUNC_MIRROR = 4'd7,
    FUNC_ROTATE = 4'd8,
    FUNC_CLEAR  = 4'd9
  } func_e;

endpackage

// ===== rtl/bitmap_16x16_transform_engine_top.sv =====
// Bitmap transform engine top level: SIDE x SIDE one-bit icon with whole-bitmap edits.
//
// The icon is held in flip-flops and cleared by reset. Every edit (invert, shift
// up/down/left/right, mirror, rotate, clear) rewrites all rows in one combinational
// step. A beat is captured in an input register. It is applied to the icon, and
// its result is loaded into the result register, once that register is free or
// being taken, and the result beat then appears on the master side. A result
// thus passes through the input register and then the result register. Throughput
// is one beat per cycle while the master side is ready, set by the combinational
// edit logic between the two registers. The input stalls only while both registers
// hold beats and the master side is not ready. Every beat yields exactly one result
// beat: the addressed row (low 16 bits) for a read row, and zero otherwise. A row
// index not below SIDE makes a write row a no-op and makes a read row return zero.
// Unused func codes leave the icon untouched. Beats are processed strictly in order.
module bitmap_16x16_transform_engine_top #(
  parameter int unsigned SIDE = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] func, [7:4] row_index, [23:8] row_data
  input  logic [bte_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] row_value
  output logic [bte_pkg::OutTdataW-1:0]    m_axis_tdata
);

  localparam int unsigned RowSelW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned CmpW0   = $clog2(SIDE + 1);
  localparam int unsigned CmpW    = (CmpW0 > bte_pkg::IdxW) ? CmpW0 : bte_pkg::IdxW;

  logic                          in_vld_q;
  logic [bte_pkg::FuncW-1:0]     func_q;
  logic [bte_pkg::IdxW-1:0]      idx_q;
  logic [bte_pkg::DataW-1:0]     data_q;
  logic                          out_vld_q;
  logic [bte_pkg::DataW-1:0]     out_q;
  logic [SIDE-1:0]               icon_q [SIDE];
  logic [SIDE-1:0]               icon_d [SIDE];
  logic [bte_pkg::DataW-1:0]     out_d;
  logic                          advance;
  logic                          s_acc;
  logic [CmpW-1:0]               idx_w;
  logic                          idx_ok;
  logic [SIDE-1:0]               wr_row;
  logic [SIDE-1:0]               rd_row;
  logic [SIDE+bte_pkg::DataW-1:0] wr_ext;
  logic [SIDE+bte_pkg::DataW-1:0] rd_ext;
  bte_pkg::func_e                func;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = bte_pkg::OutTdataW'(out_q);

  assign func   = bte_pkg::func_e'(func_q);
  assign idx_w  = CmpW'(idx_q);
  assign idx_ok = idx_w < CmpW'(SIDE);
  assign wr_ext = {{SIDE{1'b0}}, data_q};
  assign wr_row = wr_ext[SIDE-1:0];
  assign rd_row = icon_q[idx_w[RowSelW-1:0]];
  assign rd_ext = {{bte_pkg::DataW{1'b0}}, rd_row};

  always_comb begin
    icon_d = icon_q;
    out_d  = '0;
    case (func)
      bte_pkg::FUNC_WRITE: begin
        if (idx_ok) begin
          icon_d[idx_w[RowSelW-1:0]] = wr_row;
        end
      end
      bte_pkg::FUNC_READ: begin
        if (idx_ok) begin
          out_d = rd_ext[bte_pkg::DataW-1:0];
        end
      end
      bte_pkg::FUNC_INVERT: begin
        for (int r = 0; r < SIDE; r++) icon_d[r] = ~icon_q[r];
      end
      bte_pkg::FUNC_UP: begin
        for (int r = 0; r < SIDE - 1; r++) icon_d[r] = icon_q[r+1];
        icon_d[SIDE-1] = '0;
      end
      bte_pkg::FUNC_DOWN: begin
        for (int r = 1; r < SIDE; r++) icon_d[r] = icon_q[r-1];
        icon_d[0] = '0;
      end
      bte_pkg::FUNC_LEFT: begin
        for (int r = 0; r < SIDE; r++) icon_d[r] = {icon_q[r][SIDE-2:0], 1'b0};
      end
      bte_pkg::FUNC_RIGHT: begin
        for (int r = 0; r < SIDE; r++) icon_d[r] = {1'b0, icon_q[r][SIDE-1:1]};
      end
      bte_pkg::FUNC_MIRROR: begin
        for (int r = 0; r < SIDE; r++) begin
          for (int b = 0; b < SIDE; b++) icon_d[r][b] = icon_q[r][SIDE-1-b];
        end
      end
      bte_pkg::FUNC_ROTATE: begin
        for (int j = 0; j < SIDE; j++) begin
          for (int i = 0; i < SIDE; i++) icon_d[j][i] = icon_q[i][SIDE-1-j];
        end
      end
      bte_pkg::FUNC_CLEAR: begin
        for (int r = 0; r < SIDE; r++) icon_d[r] = '0;
      end
      default: begin
        icon_d = icon_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int r = 0; r < SIDE; r++) icon_q[r] <= '0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        icon_q    <= icon_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q <= s_axis_tdata[bte_pkg::FuncW-1:0];
      idx_q  <= s_axis_tdata[bte_pkg::FuncW +: bte_pkg::IdxW];
      data_q <= s_axis_tdata[bte_pkg::FuncW + bte_pkg::IdxW +: bte_pkg::DataW];
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  a_non_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (func_q != bte_pkg::FUNC_READ) |=> out_q == '0)
    else $error("non-read beat produced nonzero row_value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without a full pipe");

  a_clear_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (func_q == bte_pkg::FUNC_CLEAR) |=> icon_q[0] == '0 && icon_q[SIDE-1] == '0)
    else $error("clear left bits set");

  a_invert_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (func_q == bte_pkg::FUNC_INVERT) |=> icon_q[0] == ~$past(icon_q[0]))
    else $error("invert did not complement row 0");

  a_hold_icon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> icon_q[SIDE-1] == $past(icon_q[SIDE-1]))
    else $error("icon changed without a beat applied");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the 16x16 bitmap transform engine.
`timescale 1ns / 100ps

module testbench;

  localparam int Side       = 16;
  localparam int HoldCycles = 240;
  localparam int PhaseBeats = 160;
  localparam int NumFuncs   = 1 << bte_pkg::FuncW;

  class icon_scoreboard;
    logic [bte_pkg::DataW-1:0] icon [Side];
    logic [bte_pkg::DataW-1:0] expected_rows [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      func_seen [NumFuncs];

    function new();
      foreach (icon[i]) icon[i] = '0;
      foreach (func_seen[i]) func_seen[i] = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Apply one accepted beat to the icon copy and queue the row it returns.
    function void note_beat(logic [bte_pkg::FuncW-1:0] func, logic [bte_pkg::IdxW-1:0] idx,
                            logic [bte_pkg::DataW-1:0] data);
      logic [bte_pkg::DataW-1:0] rotated [Side];
      logic [bte_pkg::DataW-1:0] row_value;
      logic [bte_pkg::DataW-1:0] flipped;
      row_value = '0;
      func_seen[func]++;
      case (func)
        bte_pkg::FUNC_WRITE:  if (idx < Side) icon[idx] = data;
        bte_pkg::FUNC_READ:   if (idx < Side) row_value = icon[idx];
        bte_pkg::FUNC_INVERT: foreach (icon[i]) icon[i] = ~icon[i];
        bte_pkg::FUNC_UP: begin
          for (int i = 0; i < Side - 1; i++) icon[i] = icon[i+1];
          icon[Side-1] = '0;
        end
        bte_pkg::FUNC_DOWN: begin
          for (int i = Side - 1; i > 0; i--) icon[i] = icon[i-1];
          icon[0] = '0;
        end
        bte_pkg::FUNC_LEFT:   foreach (icon[i]) icon[i] = icon[i] << 1;
        bte_pkg::FUNC_RIGHT:  foreach (icon[i]) icon[i] = icon[i] >> 1;
        bte_pkg::FUNC_MIRROR: begin
          foreach (icon[i]) begin
            for (int b = 0; b < Side; b++) flipped[Side-1-b] = icon[i][b];
            icon[i] = flipped;
          end
        end
        bte_pkg::FUNC_ROTATE: begin
          for (int j = 0; j < Side; j++)
            for (int i = 0; i < Side; i++) rotated[j][i] = icon[i][Side-1-j];
          foreach (icon[i]) icon[i] = rotated[i];
        end
        bte_pkg::FUNC_CLEAR:  foreach (icon[i]) icon[i] = '0;
        default: ;
      endcase
      expected_rows.push_back(row_value);
    endfunction

    function void check_result(logic [bte_pkg::DataW-1:0] got);
      logic [bte_pkg::DataW-1:0] want;
      checked++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with none expected, expected none actual %h",
                 $time, got);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t ns: row_value mismatch, expected %h actual %h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [bte_pkg::InTdataW-1:0]    s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [bte_pkg::OutTdataW-1:0]   m_axis_tdata;

  icon_scoreboard sb = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  bit             hold_req;
  int unsigned    holds_done;
  int unsigned    beats_sent;

  always #2 clk_i = ~clk_i;

  bitmap_16x16_transform_engine_top #(.SIDE(Side)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  task automatic send_beat(logic [bte_pkg::FuncW-1:0] func, logic [bte_pkg::IdxW-1:0] idx,
                           logic [bte_pkg::DataW-1:0] data);
    logic [bte_pkg::InTdataW-1:0] beat;
    beat = '0;
    beat[bte_pkg::FuncW-1:0] = func;
    beat[bte_pkg::FuncW+bte_pkg::IdxW-1:bte_pkg::FuncW] = idx;
    beat[bte_pkg::InBits-1:bte_pkg::FuncW+bte_pkg::IdxW] = data;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= bte_pkg::InTdataW'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(func, idx, data);
    beats_sent++;
  endtask

  function automatic logic [bte_pkg::FuncW-1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return bte_pkg::FUNC_WRITE;
    if (r < 52) return bte_pkg::FUNC_READ;
    if (r < 58) return bte_pkg::FUNC_INVERT;
    if (r < 64) return bte_pkg::FUNC_UP;
    if (r < 70) return bte_pkg::FUNC_DOWN;
    if (r < 76) return bte_pkg::FUNC_LEFT;
    if (r < 82) return bte_pkg::FUNC_RIGHT;
    if (r < 88) return bte_pkg::FUNC_MIRROR;
    if (r < 94) return bte_pkg::FUNC_ROTATE;
    if (r < 96) return bte_pkg::FUNC_CLEAR;
    return bte_pkg::FuncW'($urandom_range(int'(bte_pkg::FUNC_CLEAR) + 1, NumFuncs - 1));
  endfunction

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, bit with_hold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) hold_req = 1'b1;
    repeat (PhaseBeats) begin
      send_beat(pick_func(), bte_pkg::IdxW'($urandom), bte_pkg::DataW'($urandom));
    end
  endtask

  // Output side: random backpressure plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[bte_pkg::DataW-1:0]);
    end
  end

  initial begin
    #400_000;
    $display("bitmap_16x16_transform_engine_top regression: fail");
    $finish;
  end

  initial begin
    int unsigned funcs_hit;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    holds_done     = 0;
    beats_sent     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner pixels, full and empty rows, each edit followed by a read
    send_beat(bte_pkg::FUNC_WRITE, 4'd0, 16'h8000);
    send_beat(bte_pkg::FUNC_WRITE, 4'd1, 16'h0001);
    send_beat(bte_pkg::FUNC_WRITE, 4'd15, 16'hFFFF);
    send_beat(bte_pkg::FUNC_WRITE, 4'd7, 16'hA5C3);
    send_beat(bte_pkg::FUNC_READ, 4'd7, 16'h0000);
    send_beat(bte_pkg::FUNC_INVERT, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd3, 16'hFFFF);
    send_beat(bte_pkg::FUNC_UP, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd14, 16'h0000);
    send_beat(bte_pkg::FUNC_DOWN, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd15, 16'h0000);
    send_beat(bte_pkg::FUNC_LEFT, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd1, 16'h0000);
    send_beat(bte_pkg::FUNC_RIGHT, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd1, 16'h0000);
    send_beat(bte_pkg::FUNC_MIRROR, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd7, 16'h0000);
    send_beat(bte_pkg::FUNC_ROTATE, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd0, 16'h0000);
    // unused func codes must leave the icon alone
    for (int f = int'(bte_pkg::FUNC_CLEAR) + 1; f < NumFuncs; f++)
      send_beat(bte_pkg::FuncW'(f), 4'd15, 16'hFFFF);
    send_beat(bte_pkg::FUNC_READ, 4'd15, 16'h0000);
    send_beat(bte_pkg::FUNC_CLEAR, 4'd0, 16'h0000);
    send_beat(bte_pkg::FUNC_READ, 4'd15, 16'h0000);

    run_phase(0, 0, 1'b1);
    run_phase(74, 0, 1'b0);
    run_phase(0, 74, 1'b0);
    run_phase(23, 23, 1'b0);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    funcs_hit = 0;
    foreach (sb.func_seen[i]) if (sb.func_seen[i] != 0) funcs_hit++;
    $display("Covered %0d beats over %0d of %0d func codes, %0d result beats checked,",
             beats_sent, funcs_hit, NumFuncs, sb.checked);
    $display("four throttle mixes and %0d output hold-off(s) of %0d cycles.",
             holds_done, HoldCycles);
    if (sb.mismatches == 0 && sb.expected_rows.size() == 0)
      $display("bitmap_16x16_transform_engine_top regression: pass");
    else
      $display("bitmap_16x16_transform_engine_top regression: fail");
    $finish;
  end

endmodule

// ===== bitmap_16x16_transform_engine_top.f =====
rtl/bte_pkg.sv
rtl/bitmap_16x16_transform_engine_top.sv
dv/testbench.sv
